// ===== rtl/sdw_pkg.sv =====
// sdw_pkg: shared types, codes and helpers of the stale data watchdog
// no dependencies; used by the interfaces, the ram-based core and the checker
`default_nettype none

package sdw_pkg;

  localparam int FUNC_W  = 2;
  localparam int CH_W    = 6;
  localparam int TIME_W  = 27;
  localparam int THR_W   = 28;
  localparam int CFG_A_W = 2;

  // request kinds
  typedef enum logic [FUNC_W-1:0] {
    FN_UPDATE = 2'd0,
    FN_STATUS = 2'd1,
    FN_TICK   = 2'd2,
    FN_LOAD   = 2'd3
  } func_t;

  // configuration register indexes
  localparam logic [CFG_A_W-1:0] REG_MONITOR_ENABLE = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_CHECK_INTERVAL = 2'd1;

  localparam logic [TIME_W-1:0]        INTERVAL_RST  = 27'd1000;
  localparam logic signed [THR_W-1:0]  NOT_MONITORED = -28'sd1;
  localparam logic signed [THR_W-1:0]  LOW_LIMIT     = 28'sd100;
  localparam logic signed [THR_W-1:0]  DEFAULT_TMO   = 28'sd900000;

  localparam logic EV_INTERRUPTED = 1'b0;
  localparam logic EV_RESUMED     = 1'b1;

  // one channel's stored state
  typedef struct packed {
    logic signed [THR_W-1:0] timeout;
    logic [TIME_W-1:0]       seen;
    logic                    stale;
  } sdw_entry_t;

  localparam int ENTRY_W = $bits(sdw_entry_t);

  localparam sdw_entry_t ENTRY_RST = '{
    timeout: NOT_MONITORED,
    seen:    '0,
    stale:   1'b0
  };

  // silence since last update, zero if never updated or time went back
  function automatic logic [TIME_W-1:0] elapsed_of(input logic [TIME_W-1:0] now,
                                                   input logic [TIME_W-1:0] seen);
    logic [TIME_W-1:0] d;
    d = now - seen;
    if (seen == '0 || now < seen) begin
      d = '0;
    end
    return d;
  endfunction

  // short thresholds fall back to the default timeout
  function automatic logic signed [THR_W-1:0] clamp_thr(input logic signed [THR_W-1:0] t);
    logic signed [THR_W-1:0] r;
    r = t;
    if (t < LOW_LIMIT && t != NOT_MONITORED) begin
      r = DEFAULT_TMO;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sdw_if.sv =====
// sdw_if: valid/ready channel interfaces of the stale data watchdog
// depends on sdw_pkg for field widths
`default_nettype none

interface sdw_in_if;
  logic                                valid;
  logic                                ready;
  logic [sdw_pkg::FUNC_W-1:0]          func;
  logic [sdw_pkg::CH_W-1:0]            channel;
  logic [sdw_pkg::TIME_W-1:0]          now_ms;
  logic                                ready_req;
  logic                                status_open;
  logic signed [sdw_pkg::THR_W-1:0]    threshold_ms;

  modport source (output valid, func, channel, now_ms, ready_req, status_open,
                  threshold_ms, input ready);
  modport sink   (input valid, func, channel, now_ms, ready_req, status_open,
                  threshold_ms, output ready);
endinterface

interface sdw_out_if;
  logic                        valid;
  logic                        ready;
  logic                        event_res;
  logic [sdw_pkg::CH_W-1:0]    event_channel;
  logic [sdw_pkg::TIME_W-1:0]  elapsed_ms;
  logic                        last;

  modport source (output valid, event_res, event_channel, elapsed_ms, last,
                  input ready);
  modport sink   (input valid, event_res, event_channel, elapsed_ms, last,
                  output ready);
endinterface

interface sdw_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sdw_pkg::CFG_A_W-1:0]  index;
  logic [sdw_pkg::TIME_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/sdw_ram.sv =====
// sdw_ram: generic single-write, single-read synchronous ram
// registered read data that holds while no read is issued; no dependencies
`default_nettype none

module sdw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/multi_channel_stale_data_watchdog_core.sv =====
// multi_channel_stale_data_watchdog_core: top level of the stale data watchdog
// depends on sdw_pkg, the sdw_*_if interfaces and sdw_ram
//
// usage
//   in_ch   requests: data update, status change, time tick or threshold load
//   out_ch  events: interrupted (with silence in ms) or resumed; last marks
//           the final event caused by one request
//   cfg_ch  register writes, always ready; write only while the block is idle
// timing
//   in_ch.ready is high only in the idle state; one request at a time
//   update, status change and load: accept with ram read issued, then a
//   read-modify-write (a status change only reads), waiting for room to emit
//   an event; a tick that starts a scan: accept, then one ram entry per cycle
//   while no held-back event is stalled, then release of the final event
//   events from a scan are held back by one so the last one can be marked
// reset
//   config returns to disabled, 1000 ms interval; per-entry valid bits are
//   cleared so untouched entries read as unmonitored, never updated, not stale;
//   no clearing pass, requests are taken right after reset
// back-pressure
//   while out_ch stalls, the engine holds in its state with the ram output
//   stable and takes no new request once it needs to emit
`default_nettype none

module multi_channel_stale_data_watchdog_core #(
  parameter int CHANNELS = 64
) (
  input wire logic  clk,
  input wire logic  rst_n,
  sdw_in_if.sink    in_ch,
  sdw_out_if.source out_ch,
  sdw_cfg_if.sink   cfg_ch
);

  import sdw_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [AW-1:0]   LAST_IDX = AW'(CHANNELS - 1);
  localparam logic [CH_W:0]   CH_LIM   = (CH_W + 1)'(CHANNELS);

  // one-hot engine states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ITEM  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic              en_r;
  logic [TIME_W-1:0] intv_r;
  logic [TIME_W-1:0] last_scan_r, last_scan_nxt;

  // latched request
  logic [FUNC_W-1:0]       func_r;
  logic [CH_W-1:0]         chan_r;
  logic [TIME_W-1:0]       now_r;
  logic                    ready_r;
  logic                    open_r;
  logic signed [THR_W-1:0] thr_r;

  // scan index and held-back event
  logic [AW-1:0]     idx_r, idx_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [AW-1:0]     pend_ch_r, pend_ch_nxt;
  logic [TIME_W-1:0] pend_el_r, pend_el_nxt;

  // output register
  logic              out_v_r;
  logic              out_res_r;
  logic [CH_W-1:0]   out_ch_r;
  logic [TIME_W-1:0] out_el_r;
  logic              out_last_r;

  // ram access and per-entry valid bits
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  sdw_entry_t        ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [CHANNELS-1:0] vld_r;
  logic              vld_q_r;
  sdw_entry_t        ent;

  // event push into the output register
  logic              push;
  logic              push_res;
  logic [CH_W-1:0]   push_ch;
  logic [TIME_W-1:0] push_el;
  logic              push_last;

  logic              in_acc, in_ch_ok, tick_due, out_free;
  logic [TIME_W-1:0] ent_el;
  logic              hit, resume;

  sdw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch_ok     = {1'b0, in_ch.channel} < CH_LIM;
  // 28-bit sum so the interval never wraps
  assign tick_due     = {1'b0, in_ch.now_ms} > ({1'b0, last_scan_r} + {1'b0, intv_r});
  assign out_free     = !out_v_r || out_ch.ready;

  // never-written entries read as their reset value
  assign ent    = vld_q_r ? sdw_entry_t'(ram_rdata) : ENTRY_RST;
  assign ent_el = elapsed_of(now_r, ent.seen);
  // stored thresholds are -1 or at least 100, so an unsigned compare is exact
  assign hit    = (ent.timeout != NOT_MONITORED) && !ent.stale &&
                  ({1'b0, ent_el} > ent.timeout);
  assign resume = ent.stale && ready_r;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    state_nxt     = state_r;
    last_scan_nxt = last_scan_r;
    idx_nxt       = idx_r;
    pend_v_nxt    = pend_v_r;
    pend_ch_nxt   = pend_ch_r;
    pend_el_nxt   = pend_el_r;
    ram_re        = 1'b0;
    ram_raddr     = in_ch.channel[AW-1:0];
    ram_we        = 1'b0;
    ram_waddr     = chan_r[AW-1:0];
    ram_wdata     = ent;
    push          = 1'b0;
    push_res      = EV_INTERRUPTED;
    push_ch       = chan_r;
    push_el       = '0;
    push_last     = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (func_t'(in_ch.func))
            FN_UPDATE: begin
              if (en_r && in_ch_ok) begin
                ram_re    = 1'b1;
                state_nxt = S_ITEM;
              end
            end
            FN_STATUS, FN_LOAD: begin
              if (in_ch_ok) begin
                ram_re    = 1'b1;
                state_nxt = S_ITEM;
              end
            end
            FN_TICK: begin
              if (en_r && tick_due) begin
                last_scan_nxt = in_ch.now_ms;
                ram_re        = 1'b1;
                ram_raddr     = '0;
                idx_nxt       = '0;
                state_nxt     = S_SCAN;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_ITEM: begin
        case (func_t'(func_r))
          FN_UPDATE: begin
            if (ent.timeout == NOT_MONITORED) begin
              state_nxt = S_IDLE;
            end else if (!resume || out_free) begin
              ram_we          = 1'b1;
              ram_wdata.seen  = now_r;
              ram_wdata.stale = ent.stale && !ready_r;
              push            = resume;
              push_res        = EV_RESUMED;
              state_nxt       = S_IDLE;
            end
          end
          FN_STATUS: begin
            if (out_free) begin
              push      = 1'b1;
              push_res  = open_r ? EV_RESUMED : EV_INTERRUPTED;
              push_el   = open_r ? '0 : ent_el;
              state_nxt = S_IDLE;
            end
          end
          FN_LOAD: begin
            ram_we            = 1'b1;
            ram_wdata.timeout = thr_r;
            state_nxt         = S_IDLE;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_SCAN: begin
        // a second hit needs room to release the held-back event
        if (!(hit && pend_v_r && !out_free)) begin
          if (hit) begin
            ram_we          = 1'b1;
            ram_waddr       = idx_r;
            ram_wdata.stale = 1'b1;
            push            = pend_v_r;
            push_ch         = CH_W'(pend_ch_r);
            push_el         = pend_el_r;
            push_last       = 1'b0;
            pend_v_nxt      = 1'b1;
            pend_ch_nxt     = idx_r;
            pend_el_nxt     = ent_el;
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = S_FLUSH;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            ram_re    = 1'b1;
            ram_raddr = idx_r + 1'b1;
          end
        end
      end

      S_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          push       = 1'b1;
          push_ch    = CH_W'(pend_ch_r);
          push_el    = pend_el_r;
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      en_r        <= 1'b0;
      intv_r      <= INTERVAL_RST;
      last_scan_r <= '0;
      pend_v_r    <= 1'b0;
      out_v_r     <= 1'b0;
      vld_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      last_scan_r <= last_scan_nxt;
      pend_v_r    <= pend_v_nxt;
      if (push) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_MONITOR_ENABLE: en_r   <= cfg_ch.data[0];
          REG_CHECK_INTERVAL: intv_r <= cfg_ch.data;
          default:            en_r   <= en_r;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    pend_ch_r <= pend_ch_nxt;
    pend_el_r <= pend_el_nxt;
    if (ram_re) begin
      vld_q_r <= vld_r[ram_raddr];
    end
    if (in_acc) begin
      func_r  <= in_ch.func;
      chan_r  <= in_ch.channel;
      now_r   <= in_ch.now_ms;
      ready_r <= in_ch.ready_req;
      open_r  <= in_ch.status_open;
      thr_r   <= clamp_thr(in_ch.threshold_ms);
    end
    if (push) begin
      out_res_r  <= push_res;
      out_ch_r   <= push_ch;
      out_el_r   <= push_el;
      out_last_r <= push_last;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.event_res     = out_res_r;
  assign out_ch.event_channel = out_ch_r;
  assign out_ch.elapsed_ms    = out_el_r;
  assign out_ch.last          = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/sdw_chk.sv =====
// sdw_chk: port-level checks of the stale data watchdog, bound to the top level
// depends on sdw_pkg and multi_channel_stale_data_watchdog_core
`default_nettype none

module sdw_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic                        out_event_res,
  input wire logic [sdw_pkg::CH_W-1:0]    out_event_channel,
  input wire logic [sdw_pkg::TIME_W-1:0]  out_elapsed_ms,
  input wire logic                        out_last
);

  import sdw_pkg::*;

  // a stalled event stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("event dropped while stalled");

  // a stalled event keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_event_res) && $stable(out_event_channel) &&
                                $stable(out_elapsed_ms) && $stable(out_last))
    else $error("event payload changed while stalled");

  // resumed events never carry a silence time
  a_resume_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_RESUMED |-> out_elapsed_ms == '0)
    else $error("resumed event with non-zero elapsed time");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("event offered straight after reset");

endmodule

bind multi_channel_stale_data_watchdog_core sdw_chk u_sdw_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_event_res     (out_ch.event_res),
  .out_event_channel (out_ch.event_channel),
  .out_elapsed_ms    (out_ch.elapsed_ms),
  .out_last          (out_ch.last)
);

`default_nettype wire

// ===== tb/sdw_checker.sv =====
// sdw_checker: predicts stale data watchdog events from the observed requests
// and register writes, and compares every event in order
// depends on sdw_pkg and the sdw_in_if, sdw_out_if and sdw_cfg_if interfaces
`default_nettype none

module sdw_checker #(
  parameter int CHANNELS = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sdw_in_if         in_ch,
  sdw_out_if        out_ch,
  sdw_cfg_if        cfg_ch,
  output int        fail_count,
  output int        pending,
  output int        checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import sdw_pkg::*;

  typedef struct packed {
    logic              res;
    logic [CH_W-1:0]   ch;
    logic [TIME_W-1:0] elapsed;
    logic              last;
  } watch_event_t;

  // own copy of the per-channel tables and registers
  logic signed [THR_W-1:0] tmo_tab   [CHANNELS];
  logic [TIME_W-1:0]       seen_tab  [CHANNELS];
  logic                    stale_tab [CHANNELS];
  logic [TIME_W-1:0]       scan_ms;
  logic                    enable;
  logic [TIME_W-1:0]       interval;

  watch_event_t due_q[$];
  int           mismatches;
  int           n_checked;

  function automatic watch_event_t make_event(input logic res, input int ch,
                                              input logic [TIME_W-1:0] el);
    watch_event_t ev;
    ev.res     = res;
    ev.ch      = CH_W'(ch);
    ev.elapsed = el;
    ev.last    = 1'b0;
    return ev;
  endfunction

  // silence since the last recorded update, zero if never updated or time went back
  function automatic logic [TIME_W-1:0] silence_ms(input int ch, input logic [TIME_W-1:0] now);
    if (seen_tab[ch] == '0 || now < seen_tab[ch]) begin
      return '0;
    end
    return now - seen_tab[ch];
  endfunction

  task automatic predict_events();
    func_t                   fn;
    int                      ch;
    logic [TIME_W-1:0]       now;
    logic signed [THR_W-1:0] thr;
    logic [TIME_W-1:0]       el;
    logic [TIME_W:0]         next_scan;
    watch_event_t            evs[$];
    fn  = func_t'(in_ch.func);
    ch  = int'(in_ch.channel);
    now = in_ch.now_ms;
    thr = in_ch.threshold_ms;
    case (fn)
      FN_UPDATE: begin
        if (enable && ch < CHANNELS && tmo_tab[ch] != NOT_MONITORED) begin
          seen_tab[ch] = now;
          if (stale_tab[ch] && in_ch.ready_req) begin
            stale_tab[ch] = 1'b0;
            evs.push_back(make_event(EV_RESUMED, ch, '0));
          end
        end
      end
      FN_STATUS: begin
        if (ch < CHANNELS) begin
          if (in_ch.status_open) begin
            evs.push_back(make_event(EV_RESUMED, ch, '0));
          end else begin
            evs.push_back(make_event(EV_INTERRUPTED, ch, silence_ms(ch, now)));
          end
        end
      end
      FN_TICK: begin
        next_scan = {1'b0, scan_ms} + {1'b0, interval};
        if (enable && {1'b0, now} > next_scan) begin
          scan_ms = now;
          for (int i = 0; i < CHANNELS; i++) begin
            if (tmo_tab[i] != NOT_MONITORED && !stale_tab[i]) begin
              el = silence_ms(i, now);
              if ($signed({1'b0, el}) > tmo_tab[i]) begin
                stale_tab[i] = 1'b1;
                evs.push_back(make_event(EV_INTERRUPTED, i, el));
              end
            end
          end
        end
      end
      FN_LOAD: begin
        if (ch < CHANNELS) begin
          if (thr < LOW_LIMIT && thr != NOT_MONITORED) begin
            thr = DEFAULT_TMO;
          end
          tmo_tab[ch] = thr;
        end
      end
      default: ;
    endcase
    if (evs.size() > 0) begin
      evs[evs.size()-1].last = 1'b1;
    end
    foreach (evs[k]) begin
      due_q.push_back(evs[k]);
    end
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("event %s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_event();
    watch_event_t want;
    if (due_q.size() == 0) begin
      $error("unexpected event on channel %0d, res %0d, elapsed %0d",
             out_ch.event_channel, out_ch.event_res, out_ch.elapsed_ms);
      mismatches++;
    end else begin
      want = due_q.pop_front();
      check_field("event_res", want.res, out_ch.event_res);
      check_field("event_channel", want.ch, out_ch.event_channel);
      check_field("elapsed_ms", want.elapsed, out_ch.elapsed_ms);
      check_field("last", want.last, out_ch.last);
      n_checked++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        tmo_tab[i]   = NOT_MONITORED;
        seen_tab[i]  = '0;
        stale_tab[i] = 1'b0;
      end
      scan_ms  = '0;
      enable   = 1'b0;
      interval = INTERVAL_RST;
      due_q.delete();
      mismatches = 0;
      n_checked  = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        compare_event();
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_MONITOR_ENABLE: enable = cfg_ch.data[0];
          REG_CHECK_INTERVAL: interval = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_events();
      end
    end
    fail_count <= mismatches;
    pending    <= due_q.size();
    checked    <= n_checked;
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// tb_top: regression bench of the stale data watchdog core
// drives requests with random gaps and register writes, throttles the events
// and gives the verdict; depends on sdw_pkg, the sdw_*_if interfaces and sdw_checker
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sdw_pkg::*;

  localparam int CHANNELS     = 64;
  // a scan walks every channel once, plus a little slack for the event register
  localparam int QUIET_CYCLES = CHANNELS + 8;
  localparam int LIMIT_NS     = 1_500_000;
  localparam int HOLD_CYCLES  = 400;

  logic clk = 1'b0;
  logic rst_n;

  sdw_in_if  in_ch ();
  sdw_out_if out_ch ();
  sdw_cfg_if cfg_ch ();

  int fail_count;
  int pending;
  int checked;

  // stimulus bookkeeping
  int unsigned clock_ms;
  int          focus_base;
  int          sent;
  int          ticks_sent;
  int          settings;
  int          rx_count;
  int          holds;

  multi_channel_stale_data_watchdog_core #(
    .CHANNELS(CHANNELS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  sdw_checker #(
    .CHANNELS(CHANNELS)
  ) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_ch    (cfg_ch),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #(LIMIT_NS);
    $display("multi_channel_stale_data_watchdog_core regression: fail");
    $finish;
  end

  // offer one request; valid stays high across back-to-back requests so it is
  // only ever assigned once per edge
  task automatic offer_request(input func_t f, input logic [CH_W-1:0] ch,
                               input logic [TIME_W-1:0] now, input logic rdy,
                               input logic opn, input logic signed [THR_W-1:0] thr);
    int gap;
    // every fourth stretch of forty requests goes without gaps
    gap = (((sent / 40) % 4) == 3) ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= f;
    in_ch.channel      <= ch;
    in_ch.now_ms       <= now;
    in_ch.ready_req    <= rdy;
    in_ch.status_open  <= opn;
    in_ch.threshold_ms <= thr;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    if (f == FN_TICK) begin
      ticks_sent++;
    end
  endtask

  // called right after a request was taken: drop valid, let every expected
  // event drain, then allow for a scan that finds nothing to report
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // both registers are written every time, valid held high between them
  task automatic apply_setting(input logic en, input logic [TIME_W-1:0] interval);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_MONITOR_ENABLE;
    cfg_ch.data  <= TIME_W'(en);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= REG_CHECK_INTERVAL;
    cfg_ch.data  <= interval;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    settings++;
  endtask

  // mostly short, usable timeouts, with the odd unmonitored, clamped or huge one
  function automatic logic signed [THR_W-1:0] pick_threshold();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      return THR_W'($urandom_range(100, 3000));
    end else if (r < 55) begin
      return NOT_MONITORED;
    end else if (r < 65) begin
      return THR_W'($urandom_range(0, 99));
    end else if (r < 72) begin
      return THR_W'(-int'($urandom_range(2, 134217728)));
    end else if (r < 80) begin
      return THR_W'($urandom_range(3000, 86400000));
    end
    return THR_W'($urandom_range(100, 20000));
  endfunction

  // one random phase: give a group of channels thresholds, then mostly updates
  // and ticks on that group with time creeping forward, plus some noise
  task automatic run_phase(input int n_items);
    int              pick;
    logic [CH_W-1:0] ch;
    logic [TIME_W-1:0] now;
    focus_base = $urandom_range(0, 48);
    for (int k = 0; k < 8; k++) begin
      offer_request(FN_LOAD, CH_W'(focus_base + 2 * k), TIME_W'(clock_ms),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_threshold());
    end
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 99);
      clock_ms += $urandom_range(0, 400);
      now = TIME_W'(clock_ms);
      // occasionally the time stamp steps back a little
      if ($urandom_range(0, 99) < 4) begin
        now = TIME_W'(clock_ms - $urandom_range(1, 600));
      end
      if ($urandom_range(0, 99) < 85) begin
        ch = CH_W'(focus_base + $urandom_range(0, 15));
      end else begin
        ch = CH_W'($urandom_range(0, 63));
      end
      if (pick < 48) begin
        offer_request(FN_UPDATE, ch, now, $urandom_range(0, 9) < 7,
                      1'($urandom_range(0, 1)), THR_W'($urandom));
      end else if (pick < 62) begin
        offer_request(FN_TICK, ch, now, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), THR_W'($urandom));
      end else if (pick < 74) begin
        offer_request(FN_STATUS, ch, now, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), THR_W'($urandom));
      end else if (pick < 90) begin
        offer_request(FN_LOAD, ch, now, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), pick_threshold());
      end else begin
        // noise: any kind, any fields, but never a time ahead of the clock
        offer_request(func_t'($urandom_range(0, 3)), CH_W'($urandom_range(0, 63)),
                      TIME_W'($urandom_range(0, clock_ms)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), THR_W'($urandom));
      end
    end
  endtask

  // event sink: random stalls per event, gap-free stretches, and two long
  // hold-offs so the block backs up into its request port
  initial begin
    int gap;
    int hold;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_count == 30 || rx_count == 300) begin
        out_ch.ready <= 1'b0;
        hold = 0;
        while (hold < HOLD_CYCLES) begin
          @(posedge clk);
          hold++;
        end
        holds++;
      end else begin
        gap = (((rx_count / 50) % 4) == 3) ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      rx_count++;
    end
  end

  // main sequence
  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.func         <= FN_UPDATE;
    in_ch.channel      <= '0;
    in_ch.now_ms       <= '0;
    in_ch.ready_req    <= 1'b0;
    in_ch.status_open  <= 1'b0;
    in_ch.threshold_ms <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= REG_MONITOR_ENABLE;
    cfg_ch.data        <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, monitoring off
    // status changes work while disabled, even on an unmonitored channel never updated
    offer_request(FN_STATUS, 6'd0, 27'd0, 1'b0, 1'b0, '0);
    offer_request(FN_STATUS, 6'd63, 27'd5, 1'b0, 1'b1, '0);
    // update and tick are ignored while disabled
    offer_request(FN_UPDATE, 6'd1, 27'd10, 1'b1, 1'b0, '0);
    offer_request(FN_TICK, 6'd0, 27'd5000, 1'b0, 1'b0, '0);
    // loads are taken while disabled; short and negative values other than -1 fall back
    offer_request(FN_LOAD, 6'd3, 27'd0, 1'b0, 1'b0, THR_W'(100));
    offer_request(FN_LOAD, 6'd4, 27'd0, 1'b0, 1'b0, THR_W'(50));
    offer_request(FN_LOAD, 6'd5, 27'd0, 1'b0, 1'b0, THR_W'(-7));
    offer_request(FN_LOAD, 6'd6, 27'd0, 1'b0, 1'b0, {1'b1, {(THR_W-1){1'b0}}});
    offer_request(FN_LOAD, 6'd7, 27'd0, 1'b0, 1'b0, {1'b0, {(THR_W-1){1'b1}}});
    offer_request(FN_LOAD, 6'd63, 27'd0, 1'b0, 1'b0, THR_W'(99));
    offer_request(FN_LOAD, 6'd8, 27'd0, 1'b0, 1'b0, NOT_MONITORED);
    offer_request(FN_LOAD, 6'd9, 27'd0, 1'b0, 1'b0, THR_W'(0));
    wait_quiet();

    // monitoring on, shortest scan interval
    apply_setting(1'b1, '0);
    // unmonitored channel: update dropped
    offer_request(FN_UPDATE, 6'd8, 27'd1000, 1'b1, 1'b0, '0);
    offer_request(FN_UPDATE, 6'd3, 27'd1000, 1'b1, 1'b0, '0);
    // first scan finds nothing overdue, the same time again is too early
    offer_request(FN_TICK, 6'd0, 27'd1000, 1'b0, 1'b0, '0);
    offer_request(FN_TICK, 6'd0, 27'd1000, 1'b0, 1'b0, '0);
    // one past the threshold: channel 3 goes stale
    offer_request(FN_TICK, 6'd0, 27'd1101, 1'b0, 1'b0, '0);
    offer_request(FN_STATUS, 6'd3, 27'd1300, 1'b0, 1'b0, '0);
    // update without ready keeps it stale
    offer_request(FN_UPDATE, 6'd3, 27'd1400, 1'b0, 1'b0, '0);
    // time behind the last update gives zero silence
    offer_request(FN_STATUS, 6'd3, 27'd900, 1'b0, 1'b0, '0);
    offer_request(FN_UPDATE, 6'd3, 27'd1500, 1'b1, 1'b0, '0);
    // a load keeps the stale flag and the time stamp
    offer_request(FN_LOAD, 6'd3, 27'd1500, 1'b1, 1'b1, THR_W'(2000));
    wait_quiet();

    clock_ms = 2000;
    run_phase(100);
    wait_quiet();

    apply_setting(1'b1, TIME_W'($urandom_range(200, 2000)));
    run_phase(90);
    wait_quiet();

    // disabled with a one-day interval: only status changes and loads matter
    apply_setting(1'b0, TIME_W'(86400000));
    run_phase(30);
    wait_quiet();

    // enabled but the interval is never reached, so no scan happens
    apply_setting(1'b1, TIME_W'(86400000));
    run_phase(30);
    wait_quiet();

    apply_setting(1'b1, INTERVAL_RST);
    run_phase(60);
    // last moment of the day: one scan over everything, then a status change
    offer_request(FN_UPDATE, 6'd63, TIME_W'(clock_ms), 1'b1, 1'b0, '0);
    offer_request(FN_TICK, 6'd0, TIME_W'(86399999), 1'b0, 1'b0, '0);
    offer_request(FN_STATUS, 6'd0, TIME_W'(86399999), 1'b0, 1'b0, '0);
    wait_quiet();

    $display("summary: %0d requests including %0d ticks under %0d register settings",
             sent, ticks_sent, settings);
    $display("summary: %0d events checked, event output held off %0d times under load",
             checked, holds);
    if (fail_count == 0) begin
      $display("multi_channel_stale_data_watchdog_core regression: pass");
    end else begin
      $display("multi_channel_stale_data_watchdog_core regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/sdw_pkg.sv
rtl/sdw_if.sv
rtl/sdw_ram.sv
rtl/multi_channel_stale_data_watchdog_core.sv
rtl/sdw_chk.sv
tb/sdw_checker.sv
tb/tb_top.sv
